/* rtl/whrv_pkg.sv */
// ----------------------------------------------------------------------------
// whrv_pkg
// Shared widths, constants and types of the running wave height estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package whrv_pkg;

  localparam int CELLS   = 4096;
  localparam int CELL_W  = 12;
  localparam int DT_W    = 16;
  localparam int ETA_W   = 16;
  localparam int HS_W    = 17;
  localparam int START_W = 40;
  localparam int TIME_W  = 48;
  localparam int CNT_W   = 32;
  localparam int SUM_W   = 64;
  localparam int WORD_W  = HS_W + 2 * SUM_W;

  localparam logic [HS_W-1:0]   HS_MAX   = {HS_W{1'b1}};
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_rsp_t;

endpackage

`default_nettype wire

/* rtl/whrv_ifs.sv */
// ----------------------------------------------------------------------------
// whrv_ifs
// Valid/ready channels of the estimator: samples, results and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface whrv_in_if;
  logic                      valid;
  logic                      ready;
  logic                      new_step;
  logic [15:0]               step_dt;
  logic [11:0]               cell_req;
  logic                      wet;
  logic signed [15:0]        eta;
  modport source (output valid, new_step, step_dt, cell_req, wet, eta, input ready);
  modport sink   (input valid, new_step, step_dt, cell_req, wet, eta, output ready);
endinterface

interface whrv_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] out_cell;
  logic [16:0] hs;
  logic        updated;
  modport source (output valid, out_cell, hs, updated, input ready);
  modport sink   (input valid, out_cell, hs, updated, output ready);
endinterface

interface whrv_cfg_if;
  logic        valid;
  logic        ready;
  logic [39:0] start_time;
  modport source (output valid, start_time, input ready);
  modport sink   (input valid, start_time, output ready);
endinterface

`default_nettype wire

/* rtl/wave_height_running_variance_top.sv */
// ----------------------------------------------------------------------------
// wave_height_running_variance_top
// Per-cell running significant wave height from surface elevation samples.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one transaction per cell sample; new_step on the first cell of a
//            time step advances elapsed time and, once past start_time, active time and the sample count.
//   out_ch : one transaction per sample: cell, stored height, updated flag.
//   cfg    : start_time write, always ready; write only while idle.
// After reset a clearing pass writes zeros to all 4096 cell entries, one per
// cycle; in_ch.ready stays low meanwhile.
// One sample at a time passes a sequencer around a shared bit-serial
// divide/square-root unit. A sample that recomputes the height runs a mean
// divide, a variance divide and a square root in turn; the mean
// divide is skipped while active time is zero and the variance divide when
// the variance is not positive.
// The result sits in an output register; a stalled receiver holds the block
// only once the next result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module wave_height_running_variance_top
  import whrv_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  whrv_in_if.sink   in_ch,
  whrv_out_if.source out_ch,
  whrv_cfg_if.sink  cfg
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_PROD, ST_ACC, ST_MSTART, ST_MDIV, ST_MSQ,
    ST_MCNT, ST_VSTART, ST_VDIV, ST_SQRT, ST_WRITE, ST_OUT
  } state_t;

  state_t state;

  logic [START_W-1:0] start_time;
  logic [TIME_W-1:0]  elapsed_time;
  logic [TIME_W-1:0]  active_time;
  logic [CNT_W-1:0]   sample_count;
  logic [DT_W-1:0]    cur_dt;
  logic               step_active;

  logic [CELL_W-1:0]  cell_idx;
  logic               wet;
  logic signed [ETA_W-1:0] eta;
  logic signed [32:0] prod;
  logic [31:0]        sq;

  logic signed [SUM_W-1:0] ws_new;
  logic [SUM_W-1:0]   ss_new;
  logic [HS_W-1:0]    hs_new;
  logic               upd;
  logic               neg;
  logic [15:0]        mag;
  logic [30:0]        m2;
  logic [62:0]        m2c;
  logic [CELL_W-1:0]  clr_cnt;

  unit_req_t          ureq;
  unit_rsp_t          ursp;
  logic [SUM_W-1:0]   opa;
  logic [SUM_W-1:0]   opb;
  logic [SUM_W-1:0]   ures;
  logic               unit_start_next;

  logic               ram_we;
  logic [CELL_W-1:0]  ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic [CELL_W-1:0]  ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;

  logic               in_acc;
  logic [TIME_W:0]    e_sum;
  logic [TIME_W-1:0]  e_next;
  logic [TIME_W:0]    a_sum;
  logic               act_next;
  logic signed [SUM_W:0] ws_sum;
  logic [SUM_W:0]     ss_sum;
  logic [SUM_W-1:0]   ws_mag;

  assign in_ch.ready = (state == ST_IDLE);
  assign cfg.ready   = 1'b1;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // unit start pulses: mean divide, variance divide or square root
  assign unit_start_next = (state == ST_MSTART && active_time != '0) ||
                           (state == ST_VSTART) ||
                           (state == ST_VDIV && ursp.done);

  always_comb begin
    e_sum    = {1'b0, elapsed_time} + {{(TIME_W + 1 - DT_W){1'b0}}, in_ch.step_dt};
    e_next   = e_sum[TIME_W] ? TIME_MAX : e_sum[TIME_W-1:0];
    act_next = e_next > {{(TIME_W - START_W){1'b0}}, start_time};
    a_sum    = {1'b0, active_time} + {{(TIME_W + 1 - DT_W){1'b0}}, in_ch.step_dt};
    ws_sum   = $signed({ram_rdata[SUM_W-1], ram_rdata[SUM_W-1:0]}) + 65'(prod);
    ss_sum   = {1'b0, ram_rdata[2*SUM_W-1:SUM_W]} + {33'd0, sq};
    ws_mag   = ws_new[SUM_W-1] ? (SUM_W'(0) - ws_new) : ws_new;
  end

  assign ram_raddr = (state == ST_IDLE) ? in_ch.cell_req : cell_idx;
  assign ram_we    = (state == ST_CLEAR) || (state == ST_WRITE);
  assign ram_waddr = (state == ST_CLEAR) ? clr_cnt : cell_idx;
  assign ram_wdata = (state == ST_CLEAR) ? '0 : {hs_new, ss_new, ws_new};

  whrv_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  whrv_unit u_unit (
    .clk (clk),
    .rst (rst),
    .req (ureq),
    .opa (opa),
    .opb (opb),
    .rsp (ursp),
    .res (ures)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      start_time   <= '0;
      elapsed_time <= '0;
      active_time  <= '0;
      sample_count <= '0;
      cur_dt       <= '0;
      step_active  <= 1'b0;
      ureq         <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      ureq.start <= unit_start_next;
      if (cfg.valid) begin
        start_time <= cfg.start_time;
      end
      if (out_ch.valid && out_ch.ready && state != ST_OUT) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CELL_W'(CELLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            cell_idx <= in_ch.cell_req;
            wet      <= in_ch.wet;
            eta      <= in_ch.eta;
            if (in_ch.new_step) begin
              cur_dt       <= in_ch.step_dt;
              elapsed_time <= e_next;
              step_active  <= act_next;
              if (act_next) begin
                active_time <= a_sum[TIME_W] ? TIME_MAX : a_sum[TIME_W-1:0];
                if (sample_count != CNT_MAX) begin
                  sample_count <= sample_count + 1'b1;
                end
              end
            end
            state <= ST_PROD;
          end
        end
        ST_PROD: begin
          prod  <= eta * $signed({1'b0, cur_dt});
          sq    <= 32'(eta * eta);
          state <= ST_ACC;
        end
        ST_ACC: begin
          // saturate on signed overflow of the weighted sum
          if (ws_sum[SUM_W] != ws_sum[SUM_W-1]) begin
            ws_new <= ws_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
          end else begin
            ws_new <= ws_sum[SUM_W-1:0];
          end
          ss_new <= ss_sum[SUM_W] ? {SUM_W{1'b1}} : ss_sum[SUM_W-1:0];
          hs_new <= ram_rdata[WORD_W-1:2*SUM_W];
          upd    <= 1'b0;
          if (step_active && wet) begin
            state <= (sample_count > CNT_W'(1)) ? ST_MSTART : ST_WRITE;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_MSTART: begin
          neg <= ws_new[SUM_W-1];
          if (active_time != '0) begin
            ureq.op <= OP_DIV;
            opa     <= ws_mag;
            opb     <= {{(SUM_W - TIME_W){1'b0}}, active_time};
            state   <= ST_MDIV;
          end else begin
            mag   <= '0;
            state <= ST_MSQ;
          end
        end
        ST_MDIV: begin
          if (ursp.done) begin
            if (neg) begin
              mag <= (ures > SUM_W'(32768)) ? 16'd32768 : ures[15:0];
            end else begin
              mag <= (ures > SUM_W'(32767)) ? 16'd32767 : ures[15:0];
            end
            state <= ST_MSQ;
          end
        end
        ST_MSQ: begin
          m2    <= 31'(mag * mag);
          state <= ST_MCNT;
        end
        ST_MCNT: begin
          m2c   <= 63'(m2 * sample_count);
          state <= ST_VSTART;
        end
        ST_VSTART: begin
          if (ss_new > {1'b0, m2c}) begin
            ureq.op <= OP_DIV;
            opa     <= ss_new - {1'b0, m2c};
            opb     <= {{(SUM_W - CNT_W){1'b0}}, sample_count - 1'b1};
            state   <= ST_VDIV;
          end else begin
            ureq.op <= OP_SQRT;
            opa     <= '0;
            state   <= ST_SQRT;
          end
        end
        ST_VDIV: begin
          if (ursp.done) begin
            ureq.op <= OP_SQRT;
            opa     <= ures;
            state   <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (ursp.done) begin
            hs_new <= (ures > SUM_W'(32767)) ? HS_MAX : {ures[14:0], 2'b00};
            upd    <= 1'b1;
            state  <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid    <= 1'b1;
            out_ch.out_cell <= cell_idx;
            out_ch.hs       <= hs_new;
            out_ch.updated  <= upd;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // accepted sample always goes to the product stage
  a_accept_prod: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == ST_PROD)
    else $error("accepted sample did not enter product stage");

  // sample count is monotonic outside reset
  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> sample_count >= $past(sample_count))
    else $error("sample count decreased");

  // shared unit finishes only while the sequencer waits for it
  a_unit_done: assert property (@(posedge clk) disable iff (rst)
    ursp.done |-> (state == ST_MDIV || state == ST_VDIV || state == ST_SQRT))
    else $error("unit result arrived in wrong state");

endmodule

`default_nettype wire

/* rtl/whrv_ram.sv */
// ----------------------------------------------------------------------------
// whrv_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module whrv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/whrv_unit.sv */
// ----------------------------------------------------------------------------
// whrv_unit
// Shared radix-2 divider / digit-by-digit square root, one bit per cycle.
// Divide: quotient in res. Square root: floor root.
// ----------------------------------------------------------------------------
`default_nettype none

module whrv_unit
  import whrv_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire unit_req_t        req,
  input  wire logic [SUM_W-1:0] opa,
  input  wire logic [SUM_W-1:0] opb,
  output unit_rsp_t             rsp,
  output logic      [SUM_W-1:0] res
);

  unit_op_t         op;
  logic [SUM_W+1:0] rem;
  logic [SUM_W-1:0] num;
  logic [SUM_W-1:0] den;
  logic [5:0]       cnt;
  logic [SUM_W+1:0] sh;
  logic [SUM_W+1:0] trial;
  logic [SUM_W+2:0] diff;
  logic             ge;
  logic             last;

  always_comb begin
    if (op == OP_DIV) begin
      sh    = {rem[SUM_W:0], num[SUM_W-1]};
      trial = {2'b00, den};
    end else begin
      sh    = {rem[SUM_W-1:0], num[SUM_W-1:SUM_W-2]};
      trial = {res, 2'b01};
    end
    diff = {1'b0, sh} - {1'b0, trial};
    ge   = !diff[SUM_W+2];
    last = (op == OP_DIV && cnt == 6'd63) || (op == OP_SQRT && cnt == 6'd31);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp <= '0;
    end else begin
      rsp.done <= !req.start && rsp.busy && last;
      if (req.start) begin
        rsp.busy <= 1'b1;
        op       <= req.op;
        num      <= opa;
        den      <= opb;
        rem      <= '0;
        res      <= '0;
        cnt      <= '0;
      end else if (rsp.busy) begin
        rem <= ge ? diff[SUM_W+1:0] : sh;
        res <= {res[SUM_W-2:0], ge};
        num <= (op == OP_DIV) ? {num[SUM_W-2:0], 1'b0} : {num[SUM_W-3:0], 2'b00};
        cnt <= cnt + 6'd1;
        if (last) begin
          rsp.busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire
